// File: rtl/core/sld_pkg.sv
// ----------------------------------------------------------------------------
// sld_pkg
// Types and constants shared by the shift register LED driver modules.
// ----------------------------------------------------------------------------
package sld_pkg;

   localparam int IDX_W  = 5;
   localparam int POS_W  = 4;
   localparam int MASK_W = 16;
   localparam int ADDR_W = 3;
   localparam int DATA_W = 32;

   // register select, taken from the word address bit
   localparam logic REG_ACTIVE_HIGH = 1'b0;
   localparam logic REG_ACTIVE_LOW  = 1'b1;

   typedef struct packed {
      logic [IDX_W-1:0] output_index;
      logic             led_on;
   } req_type;

   typedef struct packed {
      logic             serial_data;
      logic [POS_W-1:0] bit_position;
      logic             latch_after;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // accepted in-range request: update shadow, start shift
      logic advance;  // current beat taken
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic in_range; // request on the input names a real output
      logic last;     // current beat is the final bit of the chain
   } status_type;

endpackage

// File: rtl/core/shift_register_led_driver.sv
// ----------------------------------------------------------------------------
// shift_register_led_driver
// Sets one LED of a chained serial-in shift register, then shifts the whole
// output shadow out one bit per beat, highest output first, flagging the
// beat after which the latch strobe is due.
//
//   channel | direction | handshake        | payload
//   req     | in        | req_valid/stall  | req_type (output_index, led_on)
//   rsp     | out       | rsp_valid/stall  | rsp_type (serial_data, position,
//           |           |                  |           latch_after)
//   csr     | in/out    | psel/penable     | active_high_mask, active_low_mask
//
// An in-range request yields CHAIN_BITS beats, a figure set by the bit counter
// of the datapath. The next request is accepted in the cycle the final beat
// leaves. An out-of-range request is accepted and gives no beat. Reset clears
// masks, shadow and control. A stalled beat holds until taken.
// ----------------------------------------------------------------------------
module shift_register_led_driver
   import sld_pkg::*;
#(
   parameter int CHAIN_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   cmd_type    cmd;
   status_type status;

   assign pready = 1'b1;

   sld_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sld_dp #(
      .CHAIN_BITS (CHAIN_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .cmd      (cmd),
      .status   (status)
   );

endmodule

// File: rtl/core/sld_ctrl.sv
// ----------------------------------------------------------------------------
// sld_ctrl
// Controller: accepts requests and sequences the shift beats.
// ----------------------------------------------------------------------------
module sld_ctrl
   import sld_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_SHIFT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      accept;

   assign rsp_valid = rsp_valid_ff;

   // take a new request when idle or as the final beat leaves
   assign req_stall   = !((state_ff == ST_IDLE) ||
                          (state_ff == ST_SHIFT && status.last && !rsp_stall));
   assign accept      = req_valid && !req_stall;
   assign cmd.load    = accept && status.in_range;
   assign cmd.advance = (state_ff == ST_SHIFT) && !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.load) state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            if (cmd.advance && status.last) state_in = cmd.load ? ST_SHIFT : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = (state_in == ST_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/core/sld_dp.sv
// ----------------------------------------------------------------------------
// sld_dp
// Datapath: polarity masks, output shadow, shift copy and bit counter.
// ----------------------------------------------------------------------------
module sld_dp
   import sld_pkg::*;
#(
   parameter int CHAIN_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   input  req_type           req_data,
   output rsp_type           rsp_data,
   input  cmd_type           cmd,
   output status_type        status
);

   localparam int CNT_W = $clog2(CHAIN_BITS);

   logic [MASK_W-1:0]     high_mask_ff;
   logic [MASK_W-1:0]     low_mask_ff;
   logic [CHAIN_BITS-1:0] shadow_ff;
   logic [CHAIN_BITS-1:0] shadow_in;
   logic [CHAIN_BITS-1:0] shift_ff;
   logic [CHAIN_BITS-1:0] shift_in;
   logic [CNT_W-1:0]      cnt_ff;
   logic [CNT_W-1:0]      cnt_in;
   logic                  is_high;
   logic                  is_low;
   logic                  level;
   logic                  wr_en;

   assign wr_en = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         high_mask_ff <= '0;
         low_mask_ff  <= '0;
      end else if (wr_en) begin
         unique case (paddr[2])
            REG_ACTIVE_HIGH: high_mask_ff <= pwdata[MASK_W-1:0];
            REG_ACTIVE_LOW:  low_mask_ff  <= pwdata[MASK_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_ACTIVE_HIGH: prdata = DATA_W'(high_mask_ff);
         REG_ACTIVE_LOW:  prdata = DATA_W'(low_mask_ff);
         default:         prdata = '0;
      endcase
   end

   // outputs 16 and up have no polarity bits and always get level 0
   assign is_high = !req_data.output_index[IDX_W-1] &&
                    high_mask_ff[req_data.output_index[IDX_W-2:0]];
   assign is_low  = !req_data.output_index[IDX_W-1] &&
                    low_mask_ff[req_data.output_index[IDX_W-2:0]];
   assign level   = is_high ? req_data.led_on : (is_low ? !req_data.led_on : 1'b0);

   assign status.in_range = (32'(req_data.output_index) < CHAIN_BITS);
   assign status.last     = (cnt_ff == '0);

   always_comb begin
      shadow_in = shadow_ff;
      for (int i = 0; i < CHAIN_BITS; i++) begin
         if (32'(req_data.output_index) == i) shadow_in[i] = level;
      end
   end

   always_comb begin
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      priority if (cmd.load) begin
         shift_in = shadow_in;
         cnt_in   = CNT_W'(CHAIN_BITS - 1);
      end else if (cmd.advance) begin
         shift_in = {shift_ff[CHAIN_BITS-2:0], 1'b0};
         cnt_in   = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shadow_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (cmd.load) shadow_ff <= shadow_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
   end

   // highest output leaves first; position carries the low bits only
   assign rsp_data.serial_data  = shift_ff[CHAIN_BITS-1];
   assign rsp_data.bit_position = POS_W'(cnt_ff);
   assign rsp_data.latch_after  = status.last;

endmodule
